[rtl/core/tile_layer_fetch_decode_macros.svh]
// Assertion macros shared by the checkers of the tile layer fetch and decode block.
// Depends on nothing; included by the checker file.
`ifndef TILE_LAYER_FETCH_DECODE_MACROS_SVH
`define TILE_LAYER_FETCH_DECODE_MACROS_SVH

// Property checked on every rising edge outside of reset.
`define TLFD_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define TLFD_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/tlfd_pkg.sv]
// Package of the tile layer fetch and decode block: field widths, job and
// register codes, address constants and the palette base function. No dependencies.
package tlfd_pkg;

  localparam int FUNC_W   = 2;
  localparam int LAYER_W  = 2;
  localparam int COLUMN_W = 6;
  localparam int ROW_W    = 5;
  localparam int WORD_W   = 16;
  localparam int LINE_W   = 3;
  localparam int PAL_W    = 6;
  localparam int GFX_W    = 32;
  localparam int MAP_W    = 15;
  localparam int OFFS_W   = 20;
  localparam int COLOR_W  = 10;
  localparam int PIX_W    = 4;
  localparam int PIX_N    = GFX_W / PIX_W;
  localparam int BEAT_W   = $clog2(PIX_N);

  localparam logic [FUNC_W-1:0] FUNC_LOCATE = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_TILE   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PIXELS = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_NONE   = 2'd3;

  localparam logic [LAYER_W-1:0] LAYER_TEXT = 2'd0;
  localparam logic [LAYER_W-1:0] LAYER_A    = 2'd1;

  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 32;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_PAGE_A   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PAGE_B   = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SCROLL_X1 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SCROLL_X2 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_SCROLL_Y1 = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_SCROLL_Y2 = 3'd5;

  localparam logic [15:0] SCROLL_X_BIAS = 16'(12 * 8);
  localparam logic [8:0]  SCROLL_Y_BIAS = 9'(2 * 8);
  localparam logic [5:0]  TEXT_CELL_X   = 6'((12 * 8) >> 3);
  localparam logic [4:0]  TEXT_CELL_Y   = 5'((2 * 8) >> 3);
  localparam logic [6:0]  MAP_COL_BIAS  = 7'd2;
  localparam logic [21:0] GFX_LIMIT     = 22'(32'h300000 - 32'h20);
  localparam logic [PAL_W-1:0] PAL_BASE_A = 6'h20;
  localparam logic [PAL_W-1:0] PAL_BASE_B = 6'h28;

  function automatic logic [PAL_W-1:0] pal_base(input logic [LAYER_W-1:0] layer);
    logic [PAL_W-1:0] base;
    case (layer)
      LAYER_TEXT: base = '0;
      LAYER_A:    base = PAL_BASE_A;
      default:    base = PAL_BASE_B;
    endcase
    return base;
  endfunction

endpackage

[rtl/core/tlfd_if.sv]
// Request and result channel interfaces of the tile layer fetch and decode block.
// Depends on tlfd_pkg for the field widths.
interface tlfd_req_if;
  logic                              valid;
  logic                              ready;
  logic [tlfd_pkg::FUNC_W-1:0]       func;
  logic [tlfd_pkg::LAYER_W-1:0]      layer;
  logic [tlfd_pkg::COLUMN_W-1:0]     column;
  logic [tlfd_pkg::ROW_W-1:0]        row;
  logic [tlfd_pkg::WORD_W-1:0]       tile_word;
  logic [tlfd_pkg::LINE_W-1:0]       line_in_tile;
  logic [tlfd_pkg::PAL_W-1:0]        palette_in;
  logic [tlfd_pkg::GFX_W-1:0]        gfx_row;

  modport source (output valid, func, layer, column, row, tile_word, line_in_tile,
                  palette_in, gfx_row, input ready);
  modport sink (input valid, func, layer, column, row, tile_word, line_in_tile,
                palette_in, gfx_row, output ready);
endinterface

interface tlfd_rsp_if;
  logic                              valid;
  logic                              ready;
  logic [tlfd_pkg::MAP_W-1:0]        map_offset;
  logic [tlfd_pkg::OFFS_W-1:0]       gfx_offset;
  logic [tlfd_pkg::PAL_W-1:0]        palette_line;
  logic                              skip_tile;
  logic [tlfd_pkg::COLOR_W-1:0]      color_index;
  logic                              opaque;
  logic                              last;

  modport source (output valid, map_offset, gfx_offset, palette_line, skip_tile,
                  color_index, opaque, last, input ready);
  modport sink (input valid, map_offset, gfx_offset, palette_line, skip_tile,
                color_index, opaque, last, output ready);
endinterface

[rtl/core/tile_layer_fetch_decode.sv]
// Top level of the tile layer fetch and decode block: request register, job logic,
// result register with pixel sequencing, and the APB register file.
// Depends on tlfd_pkg and the channel interfaces in tlfd_if.sv.

// Each request passes an input register and a result register: it is accepted into the
// input register, and its first result is loaded into the result register once that
// register is free. A map word location or a tile word decode gives one result; a
// graphics row gives eight pixels, one per cycle from the result register while the
// output is ready, as the next request waits in the input register. Requests with the
// unused job code are taken and dropped without a result. Registers must be written
// through the APB port only while no request is in flight; the block does not check it.
module tile_layer_fetch_decode (
  input  logic                           clk,
  input  logic                           rst,
  tlfd_req_if.sink                       in_ch,
  tlfd_rsp_if.source                     out_ch,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [tlfd_pkg::PADDR_W-1:0]   paddr,
  input  logic [tlfd_pkg::PDATA_W-1:0]   pwdata,
  output logic [tlfd_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  logic [7:0]  page_select_a;
  logic [7:0]  page_select_b;
  logic [15:0] scroll_x_one;
  logic [15:0] scroll_x_two;
  logic [7:0]  scroll_y_one;
  logic [7:0]  scroll_y_two;

  logic [tlfd_pkg::REG_IDX_W-1:0] reg_idx;
  logic                           reg_write;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[tlfd_pkg::PADDR_W-1:2];
  assign reg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      page_select_a <= '0;
      page_select_b <= '0;
      scroll_x_one  <= '0;
      scroll_x_two  <= '0;
      scroll_y_one  <= '0;
      scroll_y_two  <= '0;
    end else if (reg_write) begin
      case (reg_idx)
        tlfd_pkg::REG_PAGE_A:    page_select_a <= pwdata[7:0];
        tlfd_pkg::REG_PAGE_B:    page_select_b <= pwdata[7:0];
        tlfd_pkg::REG_SCROLL_X1: scroll_x_one  <= pwdata[15:0];
        tlfd_pkg::REG_SCROLL_X2: scroll_x_two  <= pwdata[15:0];
        tlfd_pkg::REG_SCROLL_Y1: scroll_y_one  <= pwdata[7:0];
        tlfd_pkg::REG_SCROLL_Y2: scroll_y_two  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tlfd_pkg::REG_PAGE_A:    prdata = {24'd0, page_select_a};
      tlfd_pkg::REG_PAGE_B:    prdata = {24'd0, page_select_b};
      tlfd_pkg::REG_SCROLL_X1: prdata = {16'd0, scroll_x_one};
      tlfd_pkg::REG_SCROLL_X2: prdata = {16'd0, scroll_x_two};
      tlfd_pkg::REG_SCROLL_Y1: prdata = {24'd0, scroll_y_one};
      tlfd_pkg::REG_SCROLL_Y2: prdata = {24'd0, scroll_y_two};
      default:                 prdata = '0;
    endcase
  end

  // Input register.
  logic                              req_valid;
  logic [tlfd_pkg::FUNC_W-1:0]       req_func;
  logic [tlfd_pkg::LAYER_W-1:0]      req_layer;
  logic [tlfd_pkg::COLUMN_W-1:0]     req_column;
  logic [tlfd_pkg::ROW_W-1:0]        req_row;
  logic [tlfd_pkg::WORD_W-1:0]       req_word;
  logic [tlfd_pkg::LINE_W-1:0]       req_line;
  logic [tlfd_pkg::PAL_W-1:0]        req_pal;
  logic [tlfd_pkg::GFX_W-1:0]        req_gfx;

  // Result register.
  logic                              res_valid;
  logic [tlfd_pkg::MAP_W-1:0]        res_map_offset;
  logic [tlfd_pkg::OFFS_W-1:0]       res_gfx_offset;
  logic [tlfd_pkg::PAL_W-1:0]        res_palette_line;
  logic                              res_skip_tile;
  logic [tlfd_pkg::COLOR_W-1:0]      res_color_index;
  logic                              res_opaque;
  logic                              res_last;
  logic [tlfd_pkg::PAL_W-1:0]        pix_pal;
  logic [tlfd_pkg::GFX_W-tlfd_pkg::PIX_W-1:0] pix_rest;
  logic [tlfd_pkg::BEAT_W-1:0]       pix_beat;

  logic out_free;
  logic req_advance;
  logic res_load;
  logic res_shift;

  assign out_free    = !res_valid || (out_ch.ready && res_last);
  assign req_advance = req_valid && ((req_func == tlfd_pkg::FUNC_NONE) || out_free);
  assign res_load    = req_valid && (req_func != tlfd_pkg::FUNC_NONE) && out_free;
  assign res_shift   = res_valid && out_ch.ready && !res_last;
  assign in_ch.ready = !req_valid || req_advance;

  // Map word location.
  logic [15:0] sx_full;
  logic [8:0]  sy_full;
  logic [5:0]  cell_x;
  logic [4:0]  cell_y;
  logic [5:0]  col_wrap;
  logic [6:0]  cx;
  logic [4:0]  cy;
  logic [tlfd_pkg::MAP_W-1:0] map_next;

  always_comb begin
    if (req_layer == tlfd_pkg::LAYER_A) begin
      sx_full = scroll_x_one + tlfd_pkg::SCROLL_X_BIAS;
      sy_full = {1'b0, scroll_y_one} + tlfd_pkg::SCROLL_Y_BIAS;
    end else begin
      sx_full = scroll_x_two + tlfd_pkg::SCROLL_X_BIAS;
      sy_full = {1'b0, scroll_y_two} + tlfd_pkg::SCROLL_Y_BIAS;
    end
    if (req_layer == tlfd_pkg::LAYER_TEXT) begin
      cell_x = tlfd_pkg::TEXT_CELL_X;
      cell_y = tlfd_pkg::TEXT_CELL_Y;
    end else begin
      cell_x = sx_full[8:3];
      cell_y = sy_full[7:3];
    end
    col_wrap = req_column + cell_x;
    cx       = {1'b0, col_wrap} + tlfd_pkg::MAP_COL_BIAS;
    cy       = req_row + cell_y;
    map_next = {req_layer, 13'd0} + {3'd0, cy, 7'd0} + {7'd0, cx, 1'b0};
  end

  // Tile word decode.
  logic [1:0]  page;
  logic [14:0] page_base;
  logic [14:0] tile_num;
  logic [tlfd_pkg::OFFS_W-1:0] tile_addr;
  logic [tlfd_pkg::OFFS_W-1:0] gfx_next;
  logic [tlfd_pkg::PAL_W-1:0]  pal_next;
  logic                        skip_next;

  always_comb begin
    page = req_word[11:10];
    case (page)
      2'd1:    page_base = {page_select_a[7:4], 11'd0};
      2'd2:    page_base = {page_select_b[3:0], 11'd0};
      2'd3:    page_base = {page_select_b[7:4], 11'd0};
      default: page_base = '0;
    endcase
    tile_num  = {4'd0, req_word[12], req_word[9:0]} + page_base;
    tile_addr = {tile_num, 5'd0};
    gfx_next  = tile_addr | {15'd0, req_line, 2'b00};
    skip_next = {2'b00, tile_addr} >= tlfd_pkg::GFX_LIMIT;
    pal_next  = {3'd0, req_word[15:13]} + tlfd_pkg::pal_base(req_layer);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
      res_valid <= 1'b0;
      res_last  <= 1'b0;
      pix_beat  <= '0;
    end else begin
      if (in_ch.ready) begin
        req_valid <= in_ch.valid;
      end
      if (res_load) begin
        res_valid <= 1'b1;
        res_last  <= (req_func != tlfd_pkg::FUNC_PIXELS);
        pix_beat  <= '0;
      end else if (res_shift) begin
        res_last <= (pix_beat == tlfd_pkg::BEAT_W'(tlfd_pkg::PIX_N - 2));
        pix_beat <= pix_beat + 1'b1;
      end else if (out_ch.ready && res_last) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      req_func   <= in_ch.func;
      req_layer  <= in_ch.layer;
      req_column <= in_ch.column;
      req_row    <= in_ch.row;
      req_word   <= in_ch.tile_word;
      req_line   <= in_ch.line_in_tile;
      req_pal    <= in_ch.palette_in;
      req_gfx    <= in_ch.gfx_row;
    end
    if (res_load) begin
      res_map_offset   <= '0;
      res_gfx_offset   <= '0;
      res_palette_line <= '0;
      res_skip_tile    <= 1'b0;
      res_color_index  <= '0;
      res_opaque       <= 1'b0;
      pix_pal          <= req_pal;
      pix_rest         <= req_gfx[tlfd_pkg::GFX_W-tlfd_pkg::PIX_W-1:0];
      case (req_func)
        tlfd_pkg::FUNC_LOCATE: begin
          res_map_offset <= map_next;
        end
        tlfd_pkg::FUNC_TILE: begin
          res_gfx_offset   <= gfx_next;
          res_palette_line <= pal_next;
          res_skip_tile    <= skip_next;
        end
        default: begin
          res_color_index <= {req_pal, req_gfx[tlfd_pkg::GFX_W-1 -: tlfd_pkg::PIX_W]};
          res_opaque      <= |req_gfx[tlfd_pkg::GFX_W-1 -: tlfd_pkg::PIX_W];
        end
      endcase
    end else if (res_shift) begin
      res_color_index <= {pix_pal, pix_rest[tlfd_pkg::GFX_W-tlfd_pkg::PIX_W-1 -: tlfd_pkg::PIX_W]};
      res_opaque      <= |pix_rest[tlfd_pkg::GFX_W-tlfd_pkg::PIX_W-1 -: tlfd_pkg::PIX_W];
      pix_rest        <= {pix_rest[tlfd_pkg::GFX_W-2*tlfd_pkg::PIX_W-1:0],
                          {tlfd_pkg::PIX_W{1'b0}}};
    end
  end

  assign out_ch.valid        = res_valid;
  assign out_ch.map_offset   = res_map_offset;
  assign out_ch.gfx_offset   = res_gfx_offset;
  assign out_ch.palette_line = res_palette_line;
  assign out_ch.skip_tile    = res_skip_tile;
  assign out_ch.color_index  = res_color_index;
  assign out_ch.opaque       = res_opaque;
  assign out_ch.last         = res_last;

endmodule

[rtl/core/tlfd_checker.sv]
// Port-level checker of the tile layer fetch and decode block and its bind statement.
// Depends on tile_layer_fetch_decode_macros.svh and tlfd_pkg.
`include "tile_layer_fetch_decode_macros.svh"

module tlfd_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           out_last,
  input logic                           out_opaque,
  input logic [tlfd_pkg::COLOR_W-1:0]   out_color_index,
  input logic [tlfd_pkg::MAP_W-1:0]     out_map_offset,
  input logic [tlfd_pkg::OFFS_W-1:0]    out_gfx_offset,
  input logic                           pready
);

  `TLFD_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !out_valid, "result valid after reset")

  `TLFD_ASSERT(a_valid_holds, clk, rst, out_valid && !out_ready |=> out_valid, "result request dropped while stalled")

  `TLFD_ASSERT(a_opaque_match, clk, rst, out_valid |-> (out_opaque == (out_color_index[3:0] != 4'd0)), "opaque mark disagrees with pixel")

  `TLFD_ASSERT(a_pixel_beat_clean, clk, rst, out_valid && !out_last |-> (out_map_offset == '0) && (out_gfx_offset == '0), "pixel result carries an address")

  `TLFD_ASSERT_ALWAYS(a_pready_high, clk, pready, "APB pready low")

endmodule

bind tile_layer_fetch_decode tlfd_checker u_tlfd_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_last        (out_ch.last),
  .out_opaque      (out_ch.opaque),
  .out_color_index (out_ch.color_index),
  .out_map_offset  (out_ch.map_offset),
  .out_gfx_offset  (out_ch.gfx_offset),
  .pready          (pready)
);
